// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the directory block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LKCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define LKCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lkcd_pkg.sv =====
// Package of the LRU key cache directory: word types, cell interface structs, constants.
// No dependencies.
package lkcd_pkg;

  localparam int CACHE_ENTRIES_DEF = 32;
  localparam int SRC_W             = 16;
  localparam int HASH_W            = 32;
  localparam int KEY_W             = SRC_W + HASH_W;
  localparam int SLOT_W            = 5;

  typedef struct packed {
    logic [SRC_W-1:0]  source_id;
    logic [HASH_W-1:0] paint_hash;
    logic              bypass;
  } in_word_t;

  typedef struct packed {
    logic              bypassed;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [SRC_W-1:0]  evicted_source_id;
    logic [HASH_W-1:0] evicted_paint_hash;
  } out_word_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic             upd;
    logic             hit;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

  // Status each cell reports back.
  typedef struct packed {
    logic             valid;
    logic             match;
    logic             first_free;
    logic             victim;
    logic [KEY_W-1:0] key;
  } cell_st_t;

endpackage

// ===== hdl/lkcd_cell.sv =====
// One directory cell: valid bit, key and age rank of a single slot.
// Depends on lkcd_pkg.
module lkcd_cell #(
  parameter int CACHE_ENTRIES = lkcd_pkg::CACHE_ENTRIES_DEF,
  parameter int IDX           = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [lkcd_pkg::KEY_W-1:0]           look_key,
  input  logic                                 prev_valid,
  input  lkcd_pkg::cell_cmd_t                  cmd,
  input  logic [$clog2(CACHE_ENTRIES)-1:0]     cmd_slot,
  input  logic [$clog2(CACHE_ENTRIES)-1:0]     cmd_rank,
  output lkcd_pkg::cell_st_t                   st,
  output logic [$clog2(CACHE_ENTRIES)-1:0]     rank
);
  import lkcd_pkg::*;

  localparam int RANK_W = $clog2(CACHE_ENTRIES);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              sel;

  assign sel = (cmd_slot == RANK_W'(IDX));

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    rank_nxt  = rank_r;
    if (cmd.upd) begin
      if (sel) begin
        valid_nxt = 1'b1;
        key_nxt   = cmd.key;
        rank_nxt  = '0;
      end else if (valid_r && (!cmd.hit || (rank_r < cmd_rank))) begin
        // on a miss age every valid entry, on a hit age those younger than the touched entry
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rank_r <= rank_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign st.valid      = valid_r;
  assign st.match      = valid_r && (key_r == look_key);
  assign st.first_free = !valid_r && prev_valid;
  assign st.victim     = valid_r && (rank_r == RANK_W'(CACHE_ENTRIES - 1));
  assign st.key        = key_r;
  assign rank          = rank_r;

endmodule

// ===== hdl/lru_key_cache_directory.sv =====
// Top level of the LRU key cache directory: control sequencer over a row of cells.
// Depends on lkcd_pkg and lkcd_cell.
//
// Fully associative directory of CACHE_ENTRIES keys with least-recently-used
// replacement. Drive start with in_word while busy is low; the word is taken at
// that edge. A bypass word returns its result on the next cycle with no state
// change. A lookup word passes through the states S_LOOK and S_UPD: the accept
// edge latches the request; in S_LOOK every cell compares its key and the row
// reports hit, first free slot and oldest entry (busy is high only in this
// state); in S_UPD the result is on out_word with out_valid high and the cells
// apply the update. A new word may be accepted in S_UPD, while that update is
// applied, but not in S_LOOK. Each result is shown for exactly one cycle
// under out_valid and the receiver cannot stall it; capture it when out_valid is
// high. Slots fill lowest number first; once all are full the oldest entry is
// evicted and its key reported on the evicted fields, which read zero otherwise.
module lru_key_cache_directory #(
  parameter int CACHE_ENTRIES = lkcd_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lkcd_pkg::in_word_t  in_word,
  output logic                out_valid,
  output lkcd_pkg::out_word_t out_word
);
  import lkcd_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD} state_t;

  state_t            state_r, state_nxt;
  logic [KEY_W-1:0]  req_key_r, req_key_nxt;
  logic              dec_hit_r, dec_hit_nxt;
  logic [IDX_W-1:0]  dec_slot_r, dec_slot_nxt;
  logic [IDX_W-1:0]  dec_rank_r, dec_rank_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  cell_st_t          cell_st [CACHE_ENTRIES];
  logic [IDX_W-1:0]  cell_rank [CACHE_ENTRIES];
  cell_cmd_t         cmd;

  logic              accept;
  logic              hit_any, free_any;
  logic [IDX_W-1:0]  hit_idx, hit_rank, free_idx, vic_idx, slot_sel;
  logic [KEY_W-1:0]  vic_key;

  // Row of cells; each takes the valid bit of its lower neighbor to find the
  // first free slot.
  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    logic prev_valid;
    if (g == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cell_st[g-1].valid;
    end
    lkcd_cell #(
      .CACHE_ENTRIES(CACHE_ENTRIES),
      .IDX          (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .look_key  (req_key_r),
      .prev_valid(prev_valid),
      .cmd       (cmd),
      .cmd_slot  (dec_slot_r),
      .cmd_rank  (dec_rank_r),
      .st        (cell_st[g]),
      .rank      (cell_rank[g])
    );
  end

  assign busy   = (state_r == S_LOOK);
  assign accept = start && !busy;

  // Broadcast the update in the cycle after the lookup.
  assign cmd.upd = (state_r == S_UPD);
  assign cmd.hit = dec_hit_r;
  assign cmd.key = req_key_r;

  // Collapse the row status: hit and victim are one-hot, the first free slot too.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    hit_rank = '0;
    free_idx = '0;
    vic_idx  = '0;
    vic_key  = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (cell_st[i].match) begin
        hit_any  = 1'b1;
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | cell_rank[i];
      end
      if (cell_st[i].first_free) begin
        free_any = 1'b1;
        free_idx = free_idx | IDX_W'(i);
      end
      if (cell_st[i].victim) begin
        vic_idx = vic_idx | IDX_W'(i);
        vic_key = vic_key | cell_st[i].key;
      end
    end
  end

  assign slot_sel = hit_any ? hit_idx : (free_any ? free_idx : vic_idx);

  always_comb begin
    state_nxt     = state_r;
    req_key_nxt   = req_key_r;
    dec_hit_nxt   = dec_hit_r;
    dec_slot_nxt  = dec_slot_r;
    dec_rank_nxt  = dec_rank_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    case (state_r)
      S_IDLE, S_UPD: begin
        state_nxt = S_IDLE;
        if (accept) begin
          req_key_nxt = {in_word.source_id, in_word.paint_hash};
          if (in_word.bypass) begin
            // answer at once, leave the directory alone
            out_valid_nxt = 1'b1;
            out_word_nxt  = '0;
            out_word_nxt.bypassed = 1'b1;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_nxt     = S_UPD;
        dec_hit_nxt   = hit_any;
        dec_slot_nxt  = slot_sel;
        dec_rank_nxt  = hit_rank;
        out_valid_nxt = 1'b1;
        out_word_nxt.bypassed = 1'b0;
        out_word_nxt.hit      = hit_any;
        out_word_nxt.slot     = SLOT_W'(slot_sel);
        out_word_nxt.evicted  = !hit_any && !free_any;
        if (!hit_any && !free_any) begin
          out_word_nxt.evicted_source_id  = vic_key[KEY_W-1:HASH_W];
          out_word_nxt.evicted_paint_hash = vic_key[HASH_W-1:0];
        end else begin
          out_word_nxt.evicted_source_id  = '0;
          out_word_nxt.evicted_paint_hash = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_key_r  <= req_key_nxt;
    dec_hit_r  <= dec_hit_nxt;
    dec_slot_r <= dec_slot_nxt;
    dec_rank_r <= dec_rank_nxt;
    out_word_r <= out_word_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hdl/lkcd_chk.sv =====
// Port-level checker for the LRU key cache directory, bound to the top level.
// Depends on lkcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lkcd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input lkcd_pkg::in_word_t  in_word,
  input logic                out_valid,
  input lkcd_pkg::out_word_t out_word
);
  import lkcd_pkg::*;

  `LKCD_ASSERT_NEXT(a_bypass_next, clk, rst_n, start && !busy && in_word.bypass, out_valid && out_word.bypassed, "bypass word not answered next cycle")
  `LKCD_ASSERT_NEXT(a_lookup_busy, clk, rst_n, start && !busy && !in_word.bypass, busy && !out_valid, "lookup did not enter compare cycle")
  `LKCD_ASSERT_SAME(a_hit_no_evict, clk, rst_n, out_valid && out_word.hit, !out_word.evicted && out_word.evicted_source_id == 16'd0 && out_word.evicted_paint_hash == 32'd0, "hit reported an eviction")
  `LKCD_ASSERT_SAME(a_lookup_after_busy, clk, rst_n, out_valid && !out_word.bypassed, $past(busy), "lookup result without compare cycle")

endmodule

bind lru_key_cache_directory lkcd_chk u_lkcd_chk (.*);
